>>> hdl/dnsenc_pkg.sv
// Shared constants, types and trailer byte table for the DNS record name encoder.
package dnsenc_pkg;

  localparam int MAX_LABEL_DEF = 63;

  localparam logic [1:0] CMD_CHAR    = 2'd0;
  localparam logic [1:0] CMD_END     = 2'd1;
  localparam logic [1:0] CMD_TRAILER = 2'd2;

  localparam logic KIND_A  = 1'b0;
  localparam logic KIND_NS = 1'b1;

  localparam logic [7:0]  DOT_CHAR   = 8'h2E;
  localparam logic [15:0] TYPE_A     = 16'h0001;
  localparam logic [15:0] TYPE_NS    = 16'h0002;
  localparam logic [15:0] CLASS_IN   = 16'h0001;
  localparam logic [15:0] ADDR_RDLEN = 16'h0004;
  localparam logic [31:0] RESET_TTL  = 32'd120;

  localparam int TRAIL_IDX_W = 4;
  localparam logic [TRAIL_IDX_W-1:0] TRAIL_LAST_A  = 4'd14;
  localparam logic [TRAIL_IDX_W-1:0] TRAIL_LAST_NS = 4'd10;

  typedef logic [TRAIL_IDX_W-1:0] trail_idx_t;

  // Write and read port control into the label buffer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } buf_ctl_t;

  function automatic logic [7:0] trailer_byte(input trail_idx_t idx, input logic kind,
                                              input logic [31:0] ttl,
                                              input logic [31:0] addr);
    logic [15:0] rtype;
    logic [31:0] rttl;
    logic [15:0] rdlen;
    logic [7:0]  b;
    rtype = (kind == KIND_A) ? TYPE_A : TYPE_NS;
    rttl  = (kind == KIND_A) ? ttl : 32'd0;
    rdlen = (kind == KIND_A) ? ADDR_RDLEN : 16'd0;
    case (idx)
      4'd0:    b = 8'd0;
      4'd1:    b = rtype[15:8];
      4'd2:    b = rtype[7:0];
      4'd3:    b = CLASS_IN[15:8];
      4'd4:    b = CLASS_IN[7:0];
      4'd5:    b = rttl[31:24];
      4'd6:    b = rttl[23:16];
      4'd7:    b = rttl[15:8];
      4'd8:    b = rttl[7:0];
      4'd9:    b = rdlen[15:8];
      4'd10:   b = rdlen[7:0];
      4'd11:   b = addr[31:24];
      4'd12:   b = addr[23:16];
      4'd13:   b = addr[15:8];
      4'd14:   b = addr[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/dns_record_name_encoder_top.sv
// Top level of the DNS record name encoder: label sequencer, trailer and output register.
//
// A name character is taken and written into the label buffer. A dot, or an
// end-of-name request with characters pending, holds off the input while the label goes
// out as a length byte and its characters, one byte per cycle while the output is not
// stalled; the registered read of the label buffer is hidden by reading one character
// ahead. A trailer request sends 15 bytes for an address record and 11 for a
// name-server record, stepped through by a byte counter.
// Characters past MAX_LABEL are dropped and the flag shows on that label's output bytes.
// There is no clearing pass after reset.
module dns_record_name_encoder_top
  import dnsenc_pkg::*;
#(
  parameter int MAX_LABEL = MAX_LABEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_name_char,
  input  logic        in_record_kind,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_label_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_LABEL + 1);
  localparam logic [AW-1:0] MAX_CNT = AW'(MAX_LABEL);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LEN   = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;
  localparam logic [1:0] ST_TRAIL = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [AW-1:0] emit_cnt_r, emit_cnt_nxt;
  logic          emit_ovf_r, emit_ovf_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  trail_idx_t    tidx_r, tidx_nxt;
  logic          kind_r, kind_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   ttl_r;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          in_acc;
  logic          out_free;
  buf_ctl_t      buf_ctl;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  trail_idx_t    tlast;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign tlast     = (kind_r == KIND_A) ? TRAIL_LAST_A : TRAIL_LAST_NS;

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last           = out_last_r;
  assign out_label_overflow = out_ovf_r;

  dnsenc_label_buf #(
    .MAX_LABEL (MAX_LABEL),
    .AW        (AW)
  ) u_buf (
    .clk       (clk),
    .ctl       (buf_ctl),
    .wr_addr   (count_r),
    .wr_data   (in_name_char),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    emit_cnt_nxt  = emit_cnt_r;
    emit_ovf_nxt  = emit_ovf_r;
    idx_nxt       = idx_r;
    tidx_nxt      = tidx_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    buf_ctl.wr_en = 1'b0;
    buf_ctl.rd_en = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_command)
            CMD_CHAR: begin
              if (in_name_char == DOT_CHAR) begin
                emit_cnt_nxt = count_r;
                emit_ovf_nxt = dropped_r;
                count_nxt    = '0;
                dropped_nxt  = 1'b0;
                state_nxt    = ST_LEN;
              end else if (count_r < MAX_CNT) begin
                buf_ctl.wr_en = 1'b1;
                count_nxt     = count_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            CMD_END: begin
              if (count_r != '0) begin
                emit_cnt_nxt = count_r;
                emit_ovf_nxt = dropped_r;
                count_nxt    = '0;
                dropped_nxt  = 1'b0;
                state_nxt    = ST_LEN;
              end
            end
            CMD_TRAILER: begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
              kind_nxt    = in_record_kind;
              addr_nxt    = in_address;
              tidx_nxt    = '0;
              state_nxt   = ST_TRAIL;
            end
            default: ;
          endcase
        end
      end
      ST_LEN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'(emit_cnt_r);
          out_ovf_nxt   = emit_ovf_r;
          out_last_nxt  = (emit_cnt_r == '0);
          buf_ctl.rd_en = 1'b1;
          idx_nxt       = '0;
          state_nxt     = (emit_cnt_r == '0) ? ST_IDLE : ST_DATA;
        end
      end
      ST_DATA: begin
        rd_addr = idx_r + 1'b1;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_ovf_nxt   = emit_ovf_r;
          out_last_nxt  = (idx_r == emit_cnt_r - 1'b1);
          buf_ctl.rd_en = 1'b1;
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == emit_cnt_r - 1'b1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TRAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = trailer_byte(tidx_r, kind_r, ttl_r, addr_r);
          out_ovf_nxt   = 1'b0;
          out_last_nxt  = (tidx_r == tlast);
          tidx_nxt      = tidx_r + 1'b1;
          if (tidx_r == tlast) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ttl_r       <= RESET_TTL;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        ttl_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_cnt_r <= emit_cnt_nxt;
    emit_ovf_r <= emit_ovf_nxt;
    idx_r      <= idx_nxt;
    tidx_r     <= tidx_nxt;
    kind_r     <= kind_nxt;
    addr_r     <= addr_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("label count beyond limit");

  a_char_store: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_command == CMD_CHAR && in_name_char != DOT_CHAR && count_r < MAX_CNT
    |=> count_r == $past(count_r) + 1'b1)
    else $error("stored character not counted");

  a_data_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DATA |-> emit_cnt_r != '0 && idx_r < emit_cnt_r)
    else $error("label read past its length");

  a_trail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TRAIL |-> tidx_r <= tlast)
    else $error("trailer counter overran");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE && state_nxt == ST_IDLE |=> out_valid_r && out_last_r)
    else $error("run ended without last byte");

endmodule

>>> hdl/dnsenc_label_buf.sv
// Label character buffer: one write port, one registered read port.
module dnsenc_label_buf
  import dnsenc_pkg::*;
#(
  parameter int MAX_LABEL = MAX_LABEL_DEF,
  parameter int AW        = $clog2(MAX_LABEL + 1)
) (
  input  logic          clk,
  input  buf_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  localparam int DEPTH = 2 ** AW;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
